// ----- rtl/bal_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

    localparam int ANG_W = 24;
    localparam int CFG_W = 16;
    localparam int OUT_W = 48;
    localparam int CNT_W = 7;
    localparam int CORD_W = 34;
    localparam int TERM_W = 23;
    localparam int DVS_W = 17;

    localparam logic [17:0] PI_Q16 = 18'd205887;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
    localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [CORD_W-1:0] ONE_Q30 = 34'sd1073741824;
    localparam logic [DVS_W-1:0] LOG2E_Q16 = 17'd94549;
    // Reciprocal of LOG2E_Q16 scaled by 2^33, rounded down; the quotient estimate is then
    // short by at most one for any 33-bit partial dividend.
    localparam logic [DVS_W-1:0] LOG2E_RECIP = 17'((64'd1 << 33) / 64'(LOG2E_Q16));
    localparam logic signed [TERM_W-1:0] LOG2_MIN_Q16 = -23'sd2097152;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED,
        OP_FOLD,
        OP_CORD,
        OP_MUL1,
        OP_MUL2,
        OP_PROB,
        OP_NORM,
        OP_SQR,
        OP_ACC,
        OP_DIVI,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_FOLD,
        ST_CORD,
        ST_MUL1,
        ST_MUL2,
        ST_PROB,
        ST_NORM,
        ST_SQR,
        ST_ACC,
        ST_DIVI,
        ST_DIV,
        ST_LOAD
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_full;
    } status_t;

    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [3:0] i);
        logic signed [CORD_W-1:0] v;
        unique case (i)
            4'd0:    v = 34'sd843314857;
            4'd1:    v = 34'sd497837829;
            4'd2:    v = 34'sd263043837;
            4'd3:    v = 34'sd133525159;
            4'd4:    v = 34'sd67021687;
            4'd5:    v = 34'sd33543516;
            4'd6:    v = 34'sd16775851;
            4'd7:    v = 34'sd8388437;
            4'd8:    v = 34'sd4194283;
            4'd9:    v = 34'sd2097149;
            4'd10:   v = 34'sd1048575;
            4'd11:   v = 34'sd524288;
            4'd12:   v = 34'sd262144;
            4'd13:   v = 34'sd131072;
            4'd14:   v = 34'sd65536;
            default: v = 34'sd32768;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bal_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bal_regs
    import bal_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    output logic signed [CFG_W-1:0]      beam_asymmetry,
    output logic signed [CFG_W-1:0]      photon_polarisation
);

    logic signed [CFG_W-1:0] b_reg;
    logic signed [CFG_W-1:0] pg_reg;
    logic                    wr;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg  <= '0;
            pg_reg <= '0;
        end
        else if (wr)
        begin
            if (paddr[2])
                pg_reg <= pwdata[CFG_W-1:0];
            else
                b_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2])
            prdata = {16'd0, pg_reg};
        else
            prdata = {16'd0, b_reg};
    end

    assign beam_asymmetry = b_reg;
    assign photon_polarisation = pg_reg;

endmodule

`default_nettype wire

// ----- rtl/bal_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bal_ctrl
    import bal_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    // Each 16-bit quotient digit of the natural-log conversion takes an estimate step and a correction step.
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(2 * ((ACC_WIDTH + 31) / 16) - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cnt_next = '0;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                cmd.op = OP_RED;
                if (cnt_reg == CNT_W'(5))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.op     = OP_FOLD;
                cnt_next   = '0;
                state_next = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.op = OP_CORD;
                if (cnt_reg == CNT_W'(15))
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_PROB;
            end
            ST_PROB:
            begin
                cmd.op     = OP_PROB;
                cnt_next   = '0;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.op = OP_NORM;
                if (cnt_reg == CNT_W'(4))
                begin
                    cnt_next   = '0;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                cmd.op = OP_SQR;
                if (cnt_reg == CNT_W'(15))
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op     = OP_ACC;
                state_next = status.last ? ST_DIVI : ST_IDLE;
            end
            ST_DIVI:
            begin
                cmd.op     = OP_DIVI;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // Hold the finished sum until the previous result is taken.
                if (!status.out_full)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/bal_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bal_datapath
    import bal_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output status_t                      status,
    input  wire logic [ANG_W-1:0]        angle_rad,
    input  wire logic                    pol_negative,
    input  wire logic                    last_event,
    input  wire logic signed [CFG_W-1:0] beam_asymmetry,
    input  wire logic signed [CFG_W-1:0] photon_polarisation,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [OUT_W-1:0]             log_likelihood,
    output logic                         clamped
);

    localparam int W = ACC_WIDTH;
    localparam int NDIG = (ACC_WIDTH + 31) / 16;
    localparam int DW = NDIG * 16;
    localparam logic signed [W-1:0] ACC_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W:0] ACC_MIN_X = {2'b11, {(W-1){1'b0}}};
    localparam logic [DW-1:0] OUT_LIM = DW'(1) << (OUT_W - 1);

    // Event and angle reduction.
    logic                     angneg_reg;
    logic                     pneg_reg;
    logic                     last_reg;
    logic [ANG_W-1:0]         r_reg;
    logic                     cneg_reg;
    // CORDIC.
    logic signed [CORD_W-1:0] x_reg, y_reg, z_reg;
    // Products.
    logic signed [31:0]       bp_reg;
    logic signed [16:0]       cos_reg;
    logic signed [48:0]       prod_reg;
    // Logarithm.
    logic                     zero_reg;
    logic [30:0]              m_reg;
    logic [4:0]               sh_reg;
    logic [15:0]              frac_reg;
    // Accumulator and divider.
    logic signed [W-1:0]      sum_reg;
    logic                     clamp_reg;
    logic [DW-1:0]            dvd_reg;
    logic [DVS_W-1:0]         rem_reg;
    logic [15:0]              qd_reg;
    // Result register.
    logic                     oval_reg;
    logic [OUT_W-1:0]         oln_reg;
    logic                     oflag_reg;

    logic [ANG_W-1:0]         pi_sh;
    logic [17:0]              rr;
    logic signed [19:0]       d2;
    logic [18:0]              dabs;
    logic [18:0]              dfold;
    logic                     dbig;
    logic [3:0]               ci;
    logic signed [CORD_W-1:0] xs, ys, at;
    logic signed [CORD_W-1:0] xc;
    logic [16:0]              cosm;
    logic signed [CORD_W-1:0] a_v;
    logic signed [CORD_W:0]   psum;
    logic signed [CORD_W-1:0] p_v;
    logic [4:0]               nsh;
    logic [61:0]              sq;
    logic [31:0]              sqt;
    logic signed [TERM_W-1:0] term;
    logic signed [W:0]        sum_x;
    logic [32:0]              dt;
    logic [49:0]              qprod;
    logic [32:0]              dr;
    logic                     dfix;
    logic                     osat;

    assign pi_sh = ANG_W'(PI_Q16) << (3'd5 - cmd.step[2:0]);
    assign rr = (angneg_reg && r_reg != '0) ? (PI_Q16 - r_reg[17:0]) : r_reg[17:0];
    assign d2 = $signed({1'b0, rr, 1'b0}) - $signed({2'b00, PI_Q16});
    assign dabs = d2[19] ? 19'(-d2) : d2[18:0];
    assign dbig = dabs > {1'b0, HALF_PI_Q16};
    assign dfold = dbig ? ({1'b0, PI_Q16} - dabs) : dabs;

    assign ci = cmd.step[3:0];
    assign xs = x_reg >>> ci;
    assign ys = y_reg >>> ci;
    assign at = atan_q30(ci);

    always_comb
    begin
        if (x_reg < 0)
            xc = '0;
        else if (x_reg > ONE_Q30)
            xc = ONE_Q30;
        else
            xc = x_reg;
    end
    assign cosm = 17'((xc + CORD_W'(16384)) >>> 15);

    assign a_v = CORD_W'(prod_reg >>> 15);
    assign psum = pneg_reg ? ((CORD_W + 1)'(ONE_Q30) + (CORD_W + 1)'(a_v))
                           : ((CORD_W + 1)'(ONE_Q30) - (CORD_W + 1)'(a_v));
    assign p_v = CORD_W'(psum >>> 1);

    assign nsh = 5'd16 >> cmd.step[2:0];

    assign sq = 62'(m_reg) * 62'(m_reg);
    assign sqt = sq[61:30];

    assign term = zero_reg ? LOG2_MIN_Q16
                           : $signed(TERM_W'(frac_reg) - (TERM_W'(sh_reg) << 16));
    assign sum_x = (W + 1)'(sum_reg) + (W + 1)'(term);

    // Each quotient digit is a reciprocal estimate, then one correction.
    assign dt = {rem_reg, dvd_reg[DW-1 -: 16]};
    assign qprod = 50'(dt) * 50'(LOG2E_RECIP);
    assign dr = dt - 33'(qd_reg) * 33'(LOG2E_Q16);
    assign dfix = dr >= 33'(LOG2E_Q16);

    assign osat = dvd_reg > OUT_LIM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            clamp_reg <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            if (oval_reg && out_ready)
                oval_reg <= 1'b0;
            unique case (cmd.op)
                OP_ACC:
                begin
                    if (zero_reg)
                        clamp_reg <= 1'b1;
                    if (sum_x < ACC_MIN_X)
                    begin
                        sum_reg   <= ACC_MIN;
                        clamp_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_x[W-1:0];
                    end
                end
                OP_OUT:
                begin
                    oval_reg  <= 1'b1;
                    sum_reg   <= '0;
                    clamp_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                angneg_reg <= angle_rad[ANG_W-1];
                r_reg      <= angle_rad[ANG_W-1] ? (-angle_rad) : angle_rad;
                pneg_reg   <= pol_negative;
                last_reg   <= last_event;
            end
            OP_RED:
            begin
                if (r_reg >= pi_sh)
                    r_reg <= r_reg - pi_sh;
            end
            OP_FOLD:
            begin
                cneg_reg <= !dbig;
                x_reg    <= CORDIC_GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= $signed(CORD_W'(dfold) << 14);
            end
            OP_CORD:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
            end
            OP_MUL1:
            begin
                bp_reg  <= 32'(beam_asymmetry) * 32'(photon_polarisation);
                cos_reg <= cneg_reg ? $signed(-cosm) : $signed(cosm);
            end
            OP_MUL2:
            begin
                prod_reg <= 49'(bp_reg) * 49'(cos_reg);
            end
            OP_PROB:
            begin
                zero_reg <= (p_v <= 0);
                m_reg    <= p_v[30:0];
                sh_reg   <= '0;
                frac_reg <= '0;
            end
            OP_NORM:
            begin
                // Binary search for the leading one, widest shift first.
                if ((m_reg >> (5'd31 - nsh)) == '0)
                begin
                    m_reg  <= m_reg << nsh;
                    sh_reg <= sh_reg + nsh;
                end
            end
            OP_SQR:
            begin
                if (sqt[31])
                begin
                    m_reg    <= sqt[31:1];
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sqt[30:0];
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            OP_DIVI:
            begin
                dvd_reg <= DW'({W'(-sum_reg), 16'd0});
                rem_reg <= '0;
            end
            OP_DIV:
            begin
                if (!cmd.step[0])
                begin
                    qd_reg <= qprod[48:33];
                end
                else
                begin
                    rem_reg <= dfix ? DVS_W'(dr - 33'(LOG2E_Q16)) : dr[DVS_W-1:0];
                    dvd_reg <= {dvd_reg[DW-17:0], dfix ? (qd_reg + 16'd1) : qd_reg};
                end
            end
            OP_OUT:
            begin
                oln_reg   <= osat ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-dvd_reg);
                oflag_reg <= clamp_reg | osat;
            end
            default:
            begin
            end
        endcase
    end

    assign status.last = last_reg;
    assign status.out_full = oval_reg;
    assign out_valid = oval_reg;
    assign log_likelihood = oln_reg;
    assign clamped = oflag_reg;

endmodule

`default_nettype wire

// ----- rtl/beam_asymmetry_log_likelihood.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Beam-asymmetry log-likelihood accumulator. Each event (Q8.16 angle in s_tdata, negative
// polarisation sign in s_tuser, tlast closing the data set) adds log2 of
// (1 -/+ Pg*B*cos(2*angle))/2 to a saturating Q.16 sum; the event marked tlast also emits the
// natural-log sum in Q32.16 with a flag for any zero probability or saturation, and clears the
// sum. One event is processed at a time: the next is accepted only after six steps of angle
// reduction, sixteen CORDIC iterations and sixteen squaring steps of the logarithm on one
// shared datapath. A last event then adds the conversion to natural log, which divides by
// log2(e) in ceil((ACC_WIDTH + 16) / 16) quotient digits of sixteen bits, each a reciprocal
// estimate and a correction. The result sits in an output register, so a new data set can
// start while it waits. B and Pg are written through the APB port at addresses 0 and 4.

module beam_asymmetry_log_likelihood
    import bal_pkg::*;
#(
    parameter int ACC_WIDTH = 48
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // angle_rad[23:0]
    input  wire logic        s_tuser,   // pol_negative
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // log_likelihood[47:0]
    output logic             m_tuser,   // clamped
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cmd_t                    cmd;
    status_t                 status;
    logic signed [CFG_W-1:0] beam_asymmetry;
    logic signed [CFG_W-1:0] photon_polarisation;

    bal_regs u_regs (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .beam_asymmetry      (beam_asymmetry),
        .photon_polarisation (photon_polarisation)
    );

    bal_ctrl #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bal_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .angle_rad           (s_tdata),
        .pol_negative        (s_tuser),
        .last_event          (s_tlast),
        .beam_asymmetry      (beam_asymmetry),
        .photon_polarisation (photon_polarisation),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .log_likelihood      (m_tdata),
        .clamped             (m_tuser)
    );

endmodule

`default_nettype wire
